/* rtl/core/looped_track_interpolator_macros.svh */
// ----------------------------------------------------------------------------
// Looped track interpolator - assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOOPED_TRACK_INTERPOLATOR_MACROS_SVH
`define LOOPED_TRACK_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define LTI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lti assertion failed");

// next-cycle implication
`define LTI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lti assertion failed");

`endif

/* rtl/core/lti_pkg.sv */
// ----------------------------------------------------------------------------
// lti_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lti_pkg;

    localparam int DEF_MAX_TARGETS = 8;
    localparam int DEF_MAX_STEPS   = 64;

    // configuration register indexes
    localparam logic [2:0] CFG_N_TARGETS   = 3'd0;
    localparam logic [2:0] CFG_N_STEPS     = 3'd1;
    localparam logic [2:0] CFG_TIME_STEP   = 3'd2;
    localparam logic [2:0] CFG_SEG_TIME    = 3'd3;
    localparam logic [2:0] CFG_SEG_RECIP   = 3'd4;
    localparam logic [2:0] CFG_TRACK_DUR   = 3'd5;

    localparam logic [3:0]  RST_N_TARGETS  = 4'd1;
    localparam logic [6:0]  RST_N_STEPS    = 7'd2;
    localparam logic [31:0] RST_TIME_STEP  = 32'd65536;
    localparam logic [31:0] RST_SEG_TIME   = 32'd65536;
    localparam logic [31:0] RST_SEG_RECIP  = 32'd65536;
    localparam logic [31:0] RST_TRACK_DUR  = 32'd131072;

    // item command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // restoring remainder of a 33-bit sum
    localparam logic [5:0] DIV_STEPS = 6'd33;

    typedef struct packed {
        logic load;
        logic ind;
        logic mul;
        logic tin;
        logic rd;
        logic diff;
        logic vmul;
        logic vsat;
        logic pmul;
        logic padd;
        logic k_inc;
        logic div_init;
        logic div_step;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_last;
    } t_status;

endpackage

/* rtl/core/lti_ctrl.sv */
// ----------------------------------------------------------------------------
// lti_ctrl
// Sequencer: issues load writes and steps the datapath through a tick, one target at a time.
// ----------------------------------------------------------------------------
module lti_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_cmd,
    input  logic             i_out_ready,
    input  lti_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output lti_pkg::t_cmd    o_dp_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_IND, S_MUL, S_TIN, S_RD, S_DIFF, S_VMUL, S_VSAT,
        S_PMUL, S_PADD, S_OUT, S_DIVI, S_DIV, S_UPD
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == lti_pkg::CMD_TICK) begin
                        n_state = S_IND;
                    end else begin
                        o_dp_cmd.load = 1'b1;
                    end
                end
            end
            S_IND:  begin o_dp_cmd.ind  = 1'b1; n_state = S_MUL;  end
            S_MUL:  begin o_dp_cmd.mul  = 1'b1; n_state = S_TIN;  end
            S_TIN:  begin o_dp_cmd.tin  = 1'b1; n_state = S_RD;   end
            S_RD:   begin o_dp_cmd.rd   = 1'b1; n_state = S_DIFF; end
            S_DIFF: begin o_dp_cmd.diff = 1'b1; n_state = S_VMUL; end
            S_VMUL: begin o_dp_cmd.vmul = 1'b1; n_state = S_VSAT; end
            S_VSAT: begin o_dp_cmd.vsat = 1'b1; n_state = S_PMUL; end
            S_PMUL: begin o_dp_cmd.pmul = 1'b1; n_state = S_PADD; end
            S_PADD: begin o_dp_cmd.padd = 1'b1; n_state = S_OUT;  end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_status.last) begin
                        n_state = S_DIVI;
                    end else begin
                        o_dp_cmd.k_inc = 1'b1;
                        n_state        = S_RD;
                    end
                end
            end
            S_DIVI: begin o_dp_cmd.div_init = 1'b1; n_state = S_DIV; end
            S_DIV: begin
                o_dp_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD:  begin o_dp_cmd.upd = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

/* rtl/core/lti_dpath.sv */
// ----------------------------------------------------------------------------
// lti_dpath
// Config registers, waypoint memories, interpolation arithmetic and time loop.
// ----------------------------------------------------------------------------
module lti_dpath #(
    parameter int MAX_TARGETS = lti_pkg::DEF_MAX_TARGETS,
    parameter int MAX_STEPS   = lti_pkg::DEF_MAX_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata,
    input  logic [2:0]          i_target_sel,
    input  logic [5:0]          i_step_sel,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  lti_pkg::t_cmd       i_dp_cmd,
    output lti_pkg::t_status    o_status,
    output logic [2:0]          o_target_out,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_vel_x,
    output logic signed [31:0]  o_vel_y,
    output logic                o_last
);

    localparam int TW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int IW    = $clog2(MAX_STEPS);
    localparam int DEPTH = MAX_TARGETS * MAX_STEPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NTW   = $clog2(MAX_TARGETS + 1);
    localparam int NSW   = $clog2(MAX_STEPS + 1);

    // configuration
    logic [3:0]  r_n_targets;
    logic [6:0]  r_n_steps;
    logic [31:0] r_time_step, r_seg_time, r_seg_recip, r_track_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_targets <= lti_pkg::RST_N_TARGETS;
            r_n_steps   <= lti_pkg::RST_N_STEPS;
            r_time_step <= lti_pkg::RST_TIME_STEP;
            r_seg_time  <= lti_pkg::RST_SEG_TIME;
            r_seg_recip <= lti_pkg::RST_SEG_RECIP;
            r_track_dur <= lti_pkg::RST_TRACK_DUR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lti_pkg::CFG_N_TARGETS: r_n_targets <= i_cfg_wdata[3:0];
                lti_pkg::CFG_N_STEPS:   r_n_steps   <= i_cfg_wdata[6:0];
                lti_pkg::CFG_TIME_STEP: r_time_step <= i_cfg_wdata;
                lti_pkg::CFG_SEG_TIME:  r_seg_time  <= i_cfg_wdata;
                lti_pkg::CFG_SEG_RECIP: r_seg_recip <= i_cfg_wdata;
                lti_pkg::CFG_TRACK_DUR: r_track_dur <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped counts
    logic [NTW-1:0] nt;
    logic [NSW-1:0] ns;
    logic [IW-1:0]  ns_m1;

    always_comb begin
        if (r_n_targets == 4'd0) begin
            nt = NTW'(1);
        end else if (32'(r_n_targets) > 32'(MAX_TARGETS)) begin
            nt = NTW'(MAX_TARGETS);
        end else begin
            nt = NTW'(r_n_targets);
        end
        if (r_n_steps < 7'd2) begin
            ns = NSW'(2);
        end else if (32'(r_n_steps) > 32'(MAX_STEPS)) begin
            ns = NSW'(MAX_STEPS);
        end else begin
            ns = NSW'(r_n_steps);
        end
        ns_m1 = IW'(32'(ns) - 32'd1);
    end

    // waypoint memories
    logic [31:0] r_mem_x [DEPTH];
    logic [31:0] r_mem_y [DEPTH];
    logic [31:0] r_xa, r_xb, r_ya, r_yb;
    logic        load_ok;
    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

    logic [TW-1:0] r_k;
    logic [IW-1:0] r_ind, r_nxt;

    assign load_ok   = (32'(i_target_sel) < 32'(MAX_TARGETS)) &&
                       (32'(i_step_sel) < 32'(MAX_STEPS));
    assign wr_addr   = AW'(32'(i_target_sel) * 32'(MAX_STEPS) + 32'(i_step_sel));
    assign rd_addr_a = AW'(32'(r_k) * 32'(MAX_STEPS) + 32'(r_ind));
    assign rd_addr_b = AW'(32'(r_k) * 32'(MAX_STEPS) + 32'(r_nxt));

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load && load_ok) begin
            r_mem_x[wr_addr] <= i_point_x;
            r_mem_y[wr_addr] <= i_point_y;
        end
        if (i_dp_cmd.rd) begin
            r_xa <= r_mem_x[rd_addr_a];
            r_xb <= r_mem_x[rd_addr_b];
            r_ya <= r_mem_y[rd_addr_a];
            r_yb <= r_mem_y[rd_addr_b];
        end
    end

    // segment lookup
    logic [31:0]      r_lt;
    logic [IW+31:0]   r_seg_prod;
    logic [31:0]      r_t_in;
    logic [63:0]      ind_prod;
    logic [IW-1:0]    ind_sat;

    always_comb begin
        ind_prod = 64'(r_lt) * 64'(r_seg_recip);
        if (ind_prod[63:32] > 32'(ns_m1)) begin
            ind_sat = ns_m1;
        end else begin
            ind_sat = IW'(ind_prod[63:32]);
        end
    end

    // per-axis arithmetic
    logic signed [32:0] dx, dy;
    logic        r_neg_x, r_neg_y;
    logic [31:0] r_mag_x, r_mag_y;
    logic [63:0] r_vprod_x, r_vprod_y;
    logic [31:0] r_vmag_x, r_vmag_y, r_vel_x, r_vel_y;
    logic [63:0] r_pprod_x, r_pprod_y;
    logic [31:0] vmag_x, vmag_y, dlt_x, dlt_y;

    assign dx = {r_xb[31], r_xb} - {r_xa[31], r_xa};
    assign dy = {r_yb[31], r_yb} - {r_ya[31], r_ya};

    always_comb begin
        if (r_neg_x) begin
            vmag_x = (r_vprod_x[63:16] > 48'h8000_0000) ? 32'h8000_0000
                                                        : r_vprod_x[47:16];
        end else begin
            vmag_x = (r_vprod_x[63:16] > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                        : r_vprod_x[47:16];
        end
        if (r_neg_y) begin
            vmag_y = (r_vprod_y[63:16] > 48'h8000_0000) ? 32'h8000_0000
                                                        : r_vprod_y[47:16];
        end else begin
            vmag_y = (r_vprod_y[63:16] > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                        : r_vprod_y[47:16];
        end
        dlt_x = r_neg_x ? (32'd0 - r_pprod_x[47:16]) : r_pprod_x[47:16];
        dlt_y = r_neg_y ? (32'd0 - r_pprod_y[47:16]) : r_pprod_y[47:16];
    end

    // remainder unit for the time loop
    logic [32:0] r_rem, r_dvd, divisor;
    logic [33:0] trial;
    logic [5:0]  r_dcnt;

    assign divisor = (r_track_dur == 32'd0) ? 33'h1_0000_0000 : {1'b0, r_track_dur};
    assign trial   = {r_rem, r_dvd[32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt   <= '0;
            r_k    <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_dp_cmd.tin) begin
                r_k <= '0;
            end else if (i_dp_cmd.k_inc) begin
                r_k <= TW'(32'(r_k) + 32'd1);
            end
            if (i_dp_cmd.div_init) begin
                r_dcnt <= lti_pkg::DIV_STEPS;
            end else if (i_dp_cmd.div_step) begin
                r_dcnt <= r_dcnt - 6'd1;
            end
            if (i_dp_cmd.upd) begin
                r_lt <= r_rem[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.ind) begin
            r_ind <= ind_sat;
        end
        if (i_dp_cmd.mul) begin
            r_seg_prod <= (IW+32)'(r_ind) * (IW+32)'(r_seg_time);
            r_nxt      <= (32'(r_ind) + 32'd1 == 32'(ns)) ? '0
                                                          : IW'(32'(r_ind) + 32'd1);
        end
        if (i_dp_cmd.tin) begin
            r_t_in <= (r_seg_prod > (IW+32)'(r_lt)) ? 32'd0
                                                     : r_lt - r_seg_prod[31:0];
        end
        if (i_dp_cmd.diff) begin
            r_neg_x <= dx[32];
            r_neg_y <= dy[32];
            r_mag_x <= dx[32] ? 32'(-dx) : dx[31:0];
            r_mag_y <= dy[32] ? 32'(-dy) : dy[31:0];
        end
        if (i_dp_cmd.vmul) begin
            r_vprod_x <= 64'(r_mag_x) * 64'(r_seg_recip);
            r_vprod_y <= 64'(r_mag_y) * 64'(r_seg_recip);
        end
        if (i_dp_cmd.vsat) begin
            r_vmag_x <= vmag_x;
            r_vmag_y <= vmag_y;
            r_vel_x  <= r_neg_x ? (32'd0 - vmag_x) : vmag_x;
            r_vel_y  <= r_neg_y ? (32'd0 - vmag_y) : vmag_y;
        end
        if (i_dp_cmd.pmul) begin
            r_pprod_x <= 64'(r_vmag_x) * 64'(r_t_in);
            r_pprod_y <= 64'(r_vmag_y) * 64'(r_t_in);
        end
        if (i_dp_cmd.padd) begin
            o_pos_x      <= r_xa + dlt_x;
            o_pos_y      <= r_ya + dlt_y;
            o_vel_x      <= r_vel_x;
            o_vel_y      <= r_vel_y;
            o_target_out <= 3'(r_k);
            o_last       <= (32'(r_k) + 32'd1 == 32'(nt));
        end
        if (i_dp_cmd.div_init) begin
            r_rem <= '0;
            r_dvd <= {1'b0, r_lt} + {1'b0, r_time_step};
        end else if (i_dp_cmd.div_step) begin
            r_rem <= (trial >= {1'b0, divisor}) ? 33'(trial - {1'b0, divisor})
                                                : trial[32:0];
            r_dvd <= {r_dvd[31:0], 1'b0};
        end
    end

    assign o_status.last     = o_last;
    assign o_status.div_last = (r_dcnt == 6'd1);

endmodule

/* rtl/core/looped_track_interpolator.sv */
// ----------------------------------------------------------------------------
// looped_track_interpolator
// Looped piecewise-linear waypoint interpolator, top level.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready): a load item (cmd 0) writes one
// waypoint; a tick item (cmd 1) emits one result per active target on the
// output channel (o_out_valid/i_out_ready), last set on the final one, then
// advances local time. A tick runs segment lookup (index, multiply, time
// in segment), then per target read, diff, two registered multiplies with
// saturation, add and present, then updates local time in the bit-serial
// remainder unit. One item is worked on at a time; o_in_ready is low until
// the tick finishes. A stalled receiver holds the current result and
// pauses the sequence. Reset clears local time and loads the default
// registers; waypoint memory is not cleared and must be loaded before use.
// Configuration writes via i_cfg_we/i_cfg_idx/i_cfg_wdata take effect at
// once; they are meant for idle only, which the user must keep to, as the
// block does not enforce it.
// ----------------------------------------------------------------------------
module looped_track_interpolator #(
    parameter int MAX_TARGETS = lti_pkg::DEF_MAX_TARGETS,
    parameter int MAX_STEPS   = lti_pkg::DEF_MAX_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [2:0]         i_target_sel,
    input  logic [5:0]         i_step_sel,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_target_out,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic               o_last
);

    lti_pkg::t_cmd    dp_cmd;
    lti_pkg::t_status dp_status;

    lti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_dp_cmd    (dp_cmd)
    );

    lti_dpath #(
        .MAX_TARGETS (MAX_TARGETS),
        .MAX_STEPS   (MAX_STEPS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_target_sel (i_target_sel),
        .i_step_sel   (i_step_sel),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_dp_cmd     (dp_cmd),
        .o_status     (dp_status),
        .o_target_out (o_target_out),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_vel_x      (o_vel_x),
        .o_vel_y      (o_vel_y),
        .o_last       (o_last)
    );

endmodule

/* rtl/core/lti_checker.sv */
// ----------------------------------------------------------------------------
// lti_checker
// Port-level assertions for the looped track interpolator, bound to the top.
// ----------------------------------------------------------------------------
`include "looped_track_interpolator_macros.svh"

module lti_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_cmd,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pos_x,
    input logic        o_last
);

    // no new item is taken while a tick is still delivering
    `LTI_ASSERT_IMP(a_ready_excl, o_in_ready, !o_out_valid)

    // a tick item closes the input side on the next cycle
    `LTI_ASSERT_NXT(a_tick_busy, i_in_valid && o_in_ready && i_cmd, !o_in_ready)

    // after the last result of a tick no further result follows at once
    `LTI_ASSERT_NXT(a_last_ends, o_out_valid && i_out_ready && o_last, !o_out_valid)

    // a stalled result holds
    `LTI_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pos_x))

endmodule

bind looped_track_interpolator lti_port_checker u_lti_checker (.*);

/* bench/lti_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lti_checker
// Watches the configuration port and both item channels of the looped track
// interpolator, keeps its own waypoint table, registers and local time, and
// compares every output item with the oldest predicted fix.
// ----------------------------------------------------------------------------
module lti_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_cmd,
    input  logic [2:0]  i_target_sel,
    input  logic [5:0]  i_step_sel,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_target_out,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0]  tgt;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic        last;
    } t_fix;

    t_fix        fix_q[$];
    logic [31:0] wp_x[0:511];
    logic [31:0] wp_y[0:511];
    logic [3:0]  n_tgt;
    logic [6:0]  n_stp;
    logic [31:0] t_step, seg_time, seg_recip, loop_len, clock_now;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic logic signed [63:0] axis_velocity(logic [31:0] from, logic [31:0] to);
        logic signed [63:0] d;
        logic [63:0] mag, m;
        d = $signed({{32{to[31]}}, to}) - $signed({{32{from[31]}}, from});
        mag = (d < 0) ? -d : d;
        m = (mag * {32'd0, seg_recip}) >> 16;
        if (d < 0) begin
            if (m > 64'h8000_0000) m = 64'h8000_0000;
            return -$signed(m);
        end
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        return $signed(m);
    endfunction

    function automatic logic [31:0] axis_position(logic [31:0] from, logic signed [63:0] v,
                                                  logic [63:0] tin);
        logic [63:0] mag, m, delta;
        mag = (v < 0) ? -v : v;
        m = (mag * tin) >> 16;
        delta = (v < 0) ? -m : m;
        return from + delta[31:0];
    endfunction

    // queue the fixes of one tick, then move local time on
    function automatic void predict_fixes();
        int nt, ns;
        logic [63:0] ind, nxt, tin, sum, modulus;
        logic signed [63:0] ti, vx, vy;
        int a, b;
        t_fix f;
        nt = (n_tgt < 1) ? 1 : (n_tgt > 8) ? 8 : n_tgt;
        ns = (n_stp < 2) ? 2 : (n_stp > 64) ? 64 : n_stp;
        ind = ({32'd0, clock_now} * {32'd0, seg_recip}) >> 32;
        if (ind > ns - 1) ind = ns - 1;
        nxt = (ind + 1 == ns) ? 0 : ind + 1;
        ti = $signed({32'd0, clock_now}) - $signed(ind * {32'd0, seg_time});
        tin = (ti < 0) ? 64'd0 : ti;
        for (int k = 0; k < nt; k++) begin
            a = k * 64 + int'(ind);
            b = k * 64 + int'(nxt);
            vx = axis_velocity(wp_x[a], wp_x[b]);
            vy = axis_velocity(wp_y[a], wp_y[b]);
            f.tgt = k[2:0];
            f.pos_x = axis_position(wp_x[a], vx, tin);
            f.pos_y = axis_position(wp_y[a], vy, tin);
            f.vel_x = vx[31:0];
            f.vel_y = vy[31:0];
            f.last = (k + 1 == nt);
            fix_q = {fix_q, f};
        end
        sum = {32'd0, clock_now} + {32'd0, t_step};
        modulus = (loop_len == 0) ? 64'h1_0000_0000 : {32'd0, loop_len};
        clock_now = 32'(sum % modulus);
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_fix f;
        if (!i_rst_n) begin
            fix_q.delete();
            n_tgt = lti_pkg::RST_N_TARGETS;
            n_stp = lti_pkg::RST_N_STEPS;
            t_step = lti_pkg::RST_TIME_STEP;
            seg_time = lti_pkg::RST_SEG_TIME;
            seg_recip = lti_pkg::RST_SEG_RECIP;
            loop_len = lti_pkg::RST_TRACK_DUR;
            clock_now = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lti_pkg::CFG_N_TARGETS: n_tgt = i_cfg_wdata[3:0];
                    lti_pkg::CFG_N_STEPS:   n_stp = i_cfg_wdata[6:0];
                    lti_pkg::CFG_TIME_STEP: t_step = i_cfg_wdata;
                    lti_pkg::CFG_SEG_TIME:  seg_time = i_cfg_wdata;
                    lti_pkg::CFG_SEG_RECIP: seg_recip = i_cfg_wdata;
                    lti_pkg::CFG_TRACK_DUR: loop_len = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == lti_pkg::CMD_LOAD) begin
                    wp_x[{i_target_sel, i_step_sel}] = i_point_x;
                    wp_y[{i_target_sel, i_step_sel}] = i_point_y;
                end else begin
                    predict_fixes();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (fix_q.size() == 0) begin
                    $error("output item with no fix expected");
                    o_fail_count++;
                end else begin
                    f = fix_q.pop_front();
                    check_field("target_out", {29'd0, f.tgt}, {29'd0, i_target_out});
                    check_field("pos_x", f.pos_x, i_pos_x);
                    check_field("pos_y", f.pos_y, i_pos_y);
                    check_field("vel_x", f.vel_x, i_vel_x);
                    check_field("vel_y", f.vel_y, i_vel_y);
                    check_field("last", {31'd0, f.last}, {31'd0, i_last});
                end
            end
        end
        o_pending = fix_q.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives loads, ticks and register settings into the looped track
// interpolator under several idling patterns and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] CFG_SPARE = 3'd6;  // no register here, write ignored
    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = lti_pkg::CMD_LOAD;
    logic [2:0]  i_target_sel = '0;
    logic [5:0]  i_step_sel = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [2:0]  o_target_out;
    logic signed [31:0] o_pos_x, o_pos_y, o_vel_x, o_vel_y;
    logic        o_last;

    int fail_count, pending;
    int gap_pct = 0, stall_pct = 0;
    int hold_seq = 0, hold_seen = 0, hold_left = 0;
    int cycles = 0, items_sent = 0;
    int cur_nt = 1, cur_ns = 2;
    bit written[0:511];

    always #5 i_clk = ~i_clk;

    looped_track_interpolator dut (.*);

    lti_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_cmd(i_cmd),
        .i_target_sel(i_target_sel), .i_step_sel(i_step_sel),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_target_out(o_target_out), .i_pos_x(o_pos_x), .i_pos_y(o_pos_y),
        .i_vel_x(o_vel_x), .i_vel_y(o_vel_y), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, plus a long hold-off when asked for
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= 300;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[looped_track_interpolator] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($urandom_range(1 << 20)) - 32'(1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic cmd, logic [2:0] tgt, logic [5:0] stp,
                             logic [31:0] px, logic [31:0] py);
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_target_sel <= tgt;
        i_step_sel <= stp;
        i_point_x <= px;
        i_point_y <= py;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        if (cmd == lti_pkg::CMD_LOAD) written[{tgt, stp}] = 1'b1;
        items_sent++;
    endtask

    task automatic send_load(logic [2:0] tgt, logic [5:0] stp);
        send_item(lti_pkg::CMD_LOAD, tgt, stp, rand_coord(), rand_coord());
    endtask

    // every waypoint a tick may read must be loaded first
    task automatic send_tick();
        for (int k = 0; k < cur_nt; k++)
            for (int s = 0; s < cur_ns; s++)
                if (!written[k * 64 + s]) send_load(k[2:0], s[5:0]);
        send_item(lti_pkg::CMD_TICK, '0, '0, $urandom, $urandom);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);  // time update runs on after the last item
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [3:0] nt, logic [6:0] ns, logic [31:0] ts,
                              logic [31:0] seg, logic [31:0] rec, logic [31:0] dur);
        drain();
        cfg_write(lti_pkg::CFG_N_TARGETS, {28'd0, nt});
        cfg_write(lti_pkg::CFG_N_STEPS, {25'd0, ns});
        cfg_write(lti_pkg::CFG_TIME_STEP, ts);
        cfg_write(lti_pkg::CFG_SEG_TIME, seg);
        cfg_write(lti_pkg::CFG_SEG_RECIP, rec);
        cfg_write(lti_pkg::CFG_TRACK_DUR, dur);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_nt = (nt < 1) ? 1 : (nt > 8) ? 8 : nt;
        cur_ns = (ns < 2) ? 2 : (ns > 64) ? 64 : ns;
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 48; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 48; end
            default: begin gap_pct = 11; stall_pct = 11; end
        endcase
    endtask

    task automatic run_mix(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 30) send_load(3'($urandom_range(7)), 6'($urandom_range(63)));
            else send_tick();
        end
    endtask

    initial begin
        int phase;
        logic [31:0] seg, rec, dur, ts;
        logic [6:0] ns;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme coordinates so velocity saturates both ways
        send_item(lti_pkg::CMD_LOAD, 3'd0, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(lti_pkg::CMD_LOAD, 3'd0, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(lti_pkg::CMD_LOAD, 3'd7, 6'd63, 32'hFFFF_FFFF, 32'h0);
        repeat (3) send_item(lti_pkg::CMD_TICK, 3'd7, 6'd63, 32'h0, 32'hFFFF_FFFF);
        send_item(lti_pkg::CMD_LOAD, 3'd0, 6'd1, 32'h0001_0000, 32'hFFFF_0000);
        repeat (2) send_tick();
        drain();
        cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE + 3'd1, 32'h0);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        set_config(4'd8, 7'd4, 32'h8000, 32'h1_0000, 32'h1_0000, 32'h4_0000);
        repeat (8) send_tick();
        // zero loop length, out-of-range counts, full time step
        set_config(4'd0, 7'd127, 32'hFFFF_FFFF, 32'h400, 32'h400_0000, 32'h0);
        repeat (4) send_tick();
        set_config(4'd15, 7'd0, $urandom, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (4) send_tick();

        phase = 0;
        while (items_sent < 500) begin
            set_idling(phase);
            ns = ($urandom_range(7) == 0) ? 7'd64 : 7'($urandom_range(2, 8));
            seg = $urandom_range(1 << 10, 1 << 22);
            rec = (phase % 5 == 4) ? $urandom : 32'((64'h1_0000_0000 / seg)
                                                   - $urandom_range(0, 2));
            case ($urandom_range(2))
                0: dur = seg * ns;
                1: dur = 32'h0;
                default: dur = $urandom;
            endcase
            ts = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, seg * 2);
            set_config(4'($urandom_range(1, 8)), ns, ts, seg, rec, dur);
            if (phase == 2) begin
                hold_seq++;
                stall_pct = 0;
            end
            run_mix(40);
            phase++;
        end
        drain();
        if (fail_count == 0) begin
            $display("[looped_track_interpolator] OK");
        end else begin
            $display("[looped_track_interpolator] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lti_pkg.sv
rtl/core/lti_ctrl.sv
rtl/core/lti_dpath.sv
rtl/core/looped_track_interpolator.sv
rtl/core/lti_checker.sv
bench/lti_checker.sv
bench/testbench.sv
